>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared macros for concurrent checks on a clocked design
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check at every edge outside reset
`define VCM_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check at every edge, reset included
`define VCM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/vcm_pkg.sv
// ----------------------------------------------------------------------------
// vcm_pkg
// types, codes and helpers of the vibration condition monitor
// ----------------------------------------------------------------------------
`default_nettype none

package vcm_pkg;

  localparam int RAW_W     = 16;
  localparam int MG_W      = 12;
  localparam int MAG_W     = 12;
  localparam int LVL_W     = 12;
  localparam int SUM_W     = 24;
  localparam int REM_W     = 14;
  localparam int ACC_W     = 17;
  localparam int SEEN_W    = 5;
  localparam int EV_W      = 3;
  localparam int LEVEL_W   = 3;
  localparam int POS_W     = 4;
  localparam int CNT_W     = 5;
  localparam int COND_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int PROD_W    = 27;

  localparam int MG_SCALE   = 1000;
  localparam int MG_SHIFT   = 14;
  localparam int MG_ROUND   = (1 << MG_SHIFT) - 1;
  localparam int AXES       = 3;
  localparam int ROOT_STEPS = MAG_W;

  localparam logic [CFG_IDX_W-1:0] CFG_ELEVATED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WARNING  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CRITICAL = 2'd2;

  localparam logic [LVL_W-1:0] ELEVATED_RESET = 12'd150;
  localparam logic [LVL_W-1:0] WARNING_RESET  = 12'd300;
  localparam logic [LVL_W-1:0] CRITICAL_RESET = 12'd500;

  localparam logic [COND_W-1:0] COND_NONE     = 2'd0;
  localparam logic [COND_W-1:0] COND_NORMAL   = 2'd1;
  localparam logic [COND_W-1:0] COND_WARNING  = 2'd2;
  localparam logic [COND_W-1:0] COND_CRITICAL = 2'd3;

  localparam logic [LEVEL_W-1:0] LVL_BASELINE = 3'd0;
  localparam logic [LEVEL_W-1:0] LVL_NORMAL   = 3'd1;
  localparam logic [LEVEL_W-1:0] LVL_ELEVATED = 3'd2;
  localparam logic [LEVEL_W-1:0] LVL_WARNING  = 3'd3;
  localparam logic [LEVEL_W-1:0] LVL_CRITICAL = 3'd4;

  localparam logic [EV_W-1:0] EV_SELFTEST = 3'd0;
  localparam logic [EV_W-1:0] EV_VALID    = 3'd1;
  localparam logic [EV_W-1:0] EV_NORMAL   = 3'd2;
  localparam logic [EV_W-1:0] EV_WARNING  = 3'd3;
  localparam logic [EV_W-1:0] EV_CRITICAL = 3'd4;

  localparam logic KIND_ENTRY  = 1'b0;
  localparam logic KIND_REPORT = 1'b1;
  localparam logic FUNC_SAMPLE = 1'b0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SELF,
    ST_CONV,
    ST_SQ,
    ST_ROOT,
    ST_FIRST,
    ST_EVAL,
    ST_DIV,
    ST_BASE,
    ST_JUDGE,
    ST_LOG,
    ST_DUMP_INIT,
    ST_DUMP_RD,
    ST_DUMP_WR,
    ST_REPORT
  } state_t;

  typedef struct packed {
    logic            capture;
    logic            conv;
    logic            sq_en;
    logic            sq_first;
    logic [1:0]      axis;
    logic            root_step;
    logic            mark_first;
    logic            eval;
    logic            div_step;
    logic            base_set;
    logic            judge;
    logic            log_en;
    logic [EV_W-1:0] log_ev;
    logic            set_cond;
    logic            dump_start;
    logic            rd_en;
    logic            entry_load;
    logic            report_load;
  } cmd_t;

  typedef struct packed {
    logic              self_test_ok;
    logic              first_logged;
    logic              completing;
    logic [COND_W-1:0] cond;
    logic [COND_W-1:0] last_cond;
    logic              dump_last;
    logic              out_free;
  } sts_t;

  typedef struct packed {
    logic                   kind;
    logic signed [MG_W-1:0] x_mg;
    logic signed [MG_W-1:0] y_mg;
    logic signed [MG_W-1:0] z_mg;
    logic [MAG_W-1:0]       magnitude_mg;
    logic [MAG_W-1:0]       deviation_mg;
    logic                   baseline_done;
    logic [LEVEL_W-1:0]     vibration_level;
    logic [POS_W-1:0]       entry_position;
    logic [EV_W-1:0]        entry_event;
    logic                   last;
  } res_t;

  // raw counts to milli-g, truncated toward zero
  function automatic logic signed [MG_W-1:0] to_mg(input logic signed [RAW_W-1:0] raw);
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] adj;
    logic signed [PROD_W-1:0] shifted;
    prod    = $signed(PROD_W'(raw)) * $signed(PROD_W'(MG_SCALE));
    adj     = prod[PROD_W-1] ? prod + $signed(PROD_W'(MG_ROUND)) : prod;
    shifted = adj >>> MG_SHIFT;
    return shifted[MG_W-1:0];
  endfunction

  function automatic logic [EV_W-1:0] cond_event(input logic [COND_W-1:0] cond);
    logic [EV_W-1:0] ev;
    case (cond)
      COND_NORMAL:   ev = EV_NORMAL;
      COND_WARNING:  ev = EV_WARNING;
      COND_CRITICAL: ev = EV_CRITICAL;
      default:       ev = EV_NORMAL;
    endcase
    return ev;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/vcm_if.sv
// ----------------------------------------------------------------------------
// vcm channel interfaces
// sample input channel and result output channel, valid/ready
// ----------------------------------------------------------------------------
`default_nettype none

interface vcm_in_if;
  import vcm_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    func;
  logic signed [RAW_W-1:0] raw_x;
  logic signed [RAW_W-1:0] raw_y;
  logic signed [RAW_W-1:0] raw_z;
  logic                    self_test_ok;

  modport source (output valid, input ready, output func, output raw_x, output raw_y,
                  output raw_z, output self_test_ok);
  modport sink (input valid, output ready, input func, input raw_x, input raw_y,
                input raw_z, input self_test_ok);
endinterface

interface vcm_out_if;
  import vcm_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   kind;
  logic signed [MG_W-1:0] x_mg;
  logic signed [MG_W-1:0] y_mg;
  logic signed [MG_W-1:0] z_mg;
  logic [MAG_W-1:0]       magnitude_mg;
  logic [MAG_W-1:0]       deviation_mg;
  logic                   baseline_done;
  logic [LEVEL_W-1:0]     vibration_level;
  logic [POS_W-1:0]       entry_position;
  logic [EV_W-1:0]        entry_event;
  logic                   last;

  modport source (output valid, input ready, output kind, output x_mg, output y_mg,
                  output z_mg, output magnitude_mg, output deviation_mg,
                  output baseline_done, output vibration_level, output entry_position,
                  output entry_event, output last);
  modport sink (input valid, output ready, input kind, input x_mg, input y_mg,
                input z_mg, input magnitude_mg, input deviation_mg,
                input baseline_done, input vibration_level, input entry_position,
                input entry_event, input last);
endinterface

`default_nettype wire

>>> rtl/core/vcm_datapath.sv
// ----------------------------------------------------------------------------
// vcm_datapath
// conversion, square root, baseline, grading, history memory, output register
// ----------------------------------------------------------------------------
`default_nettype none

module vcm_datapath #(
  parameter int HISTORY_DEPTH    = 10,
  parameter int BASELINE_SAMPLES = 20
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [vcm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [vcm_pkg::LVL_W-1:0]        cfg_data,
  input  wire logic signed [vcm_pkg::RAW_W-1:0] raw_x,
  input  wire logic signed [vcm_pkg::RAW_W-1:0] raw_y,
  input  wire logic signed [vcm_pkg::RAW_W-1:0] raw_z,
  input  wire logic                             self_test_ok,
  input  wire vcm_pkg::cmd_t                    cmd,
  output vcm_pkg::sts_t                         sts,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output vcm_pkg::res_t                         out_data
);
  import vcm_pkg::*;

  localparam int AW     = $clog2(HISTORY_DEPTH);
  localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
  localparam logic [SEEN_W:0] DIVISOR = (SEEN_W + 1)'(BASELINE_SAMPLES);
  // reciprocal of the sample count, exact for any accumulator value
  localparam int QUOT_SHIFT = ACC_W + $clog2(BASELINE_SAMPLES);
  localparam logic [ACC_W:0] RECIP =
    (ACC_W + 1)'(((1 << QUOT_SHIFT) + BASELINE_SAMPLES - 1) / BASELINE_SAMPLES);

  logic [LVL_W-1:0] elevated_level;
  logic [LVL_W-1:0] warning_level;
  logic [LVL_W-1:0] critical_level;

  logic signed [RAW_W-1:0] cap_x;
  logic signed [RAW_W-1:0] cap_y;
  logic signed [RAW_W-1:0] cap_z;
  logic                    cap_ok;

  logic signed [MG_W-1:0] x_mg;
  logic signed [MG_W-1:0] y_mg;
  logic signed [MG_W-1:0] z_mg;

  logic [SUM_W-1:0] rad;
  logic [REM_W-1:0] rem;
  logic [MAG_W-1:0] root;

  logic               first_logged;
  logic [ACC_W-1:0]   acc;
  logic [SEEN_W-1:0]  seen;
  logic [MAG_W-1:0]   baseline;
  logic               base_valid;
  logic [MAG_W-1:0]   dev;
  logic [ACC_W-1:0]   div_num;
  logic [COND_W-1:0]  cond;
  logic [LEVEL_W-1:0] level;
  logic [COND_W-1:0]  last_cond;

  logic [EV_W-1:0]   mem [HISTORY_DEPTH];
  logic [AW-1:0]     wr_pos;
  logic [FILL_W-1:0] fill;
  logic [AW-1:0]     rd_ptr;
  logic [FILL_W-1:0] idx;
  logic [EV_W-1:0]   rd_data;

  logic signed [MG_W-1:0]   axis_val;
  logic signed [SUM_W-1:0]  sq_full;
  logic [SUM_W-1:0]         sq;
  logic [REM_W+1:0]         rem_sh;
  logic [REM_W+1:0]         trial;
  logic                     root_bit;
  logic [ACC_W-1:0]         acc_sum;
  logic [MAG_W-1:0]         abs_diff;
  logic [SEEN_W:0]          seen_inc;
  logic [2*ACC_W:0]         div_prod;
  logic [COND_W-1:0]        cond_next;
  logic [LEVEL_W-1:0]       level_next;
  logic [31:0]              pos32;
  logic [FILL_W-1:0]        idx_inc;
  res_t                     load_word;

  always_comb begin
    case (cmd.axis)
      2'd0:    axis_val = x_mg;
      2'd1:    axis_val = y_mg;
      default: axis_val = z_mg;
    endcase
    sq_full  = axis_val * axis_val;
    sq       = $unsigned(sq_full);
    rem_sh   = {rem, rad[SUM_W-1 -: 2]};
    trial    = {2'b00, root, 2'b01};
    root_bit = (rem_sh >= trial);
    acc_sum  = acc + ACC_W'(root);
    abs_diff = (root >= baseline) ? root - baseline : baseline - root;
    seen_inc = {1'b0, seen} + (SEEN_W + 1)'(1);
    div_prod = div_num * RECIP;
    idx_inc  = idx + FILL_W'(1);
    pos32    = 32'(idx_inc);
  end

  always_comb begin
    if (!base_valid) begin
      cond_next  = COND_NONE;
      level_next = LVL_BASELINE;
    end else if (dev >= critical_level) begin
      cond_next  = COND_CRITICAL;
      level_next = LVL_CRITICAL;
    end else if (dev >= warning_level) begin
      cond_next  = COND_WARNING;
      level_next = LVL_WARNING;
    end else begin
      cond_next  = COND_NORMAL;
      level_next = (dev >= elevated_level) ? LVL_ELEVATED : LVL_NORMAL;
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      elevated_level <= ELEVATED_RESET;
      warning_level  <= WARNING_RESET;
      critical_level <= CRITICAL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ELEVATED: elevated_level <= cfg_data;
        CFG_WARNING:  warning_level  <= cfg_data;
        CFG_CRITICAL: critical_level <= cfg_data;
        default: ;
      endcase
    end
  end

  // payload path
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cap_x  <= raw_x;
      cap_y  <= raw_y;
      cap_z  <= raw_z;
      cap_ok <= self_test_ok;
    end
    if (cmd.conv) begin
      x_mg <= to_mg(cap_x);
      y_mg <= to_mg(cap_y);
      z_mg <= to_mg(cap_z);
    end
    if (cmd.sq_en) begin
      rad <= cmd.sq_first ? sq : rad + sq;
      if (cmd.sq_first) begin
        rem  <= '0;
        root <= '0;
      end
    end
    if (cmd.root_step) begin
      rad  <= rad << 2;
      root <= {root[MAG_W-2:0], root_bit};
      rem  <= root_bit ? REM_W'(rem_sh - trial) : rem_sh[REM_W-1:0];
    end
    if (cmd.eval) begin
      dev <= base_valid ? abs_diff : '0;
      if (!base_valid) begin
        div_num <= acc_sum;
      end
    end
    if (cmd.div_step) begin
      div_num <= ACC_W'(div_prod >> QUOT_SHIFT);
    end
    if (cmd.base_set) begin
      baseline <= div_num[MAG_W-1:0];
    end
    if (cmd.judge) begin
      cond  <= cond_next;
      level <= level_next;
    end
  end

  // baseline and condition state
  always_ff @(posedge clk) begin
    if (rst) begin
      first_logged <= 1'b0;
      acc          <= '0;
      seen         <= '0;
      base_valid   <= 1'b0;
      last_cond    <= COND_NONE;
    end else begin
      if (cmd.mark_first) begin
        first_logged <= 1'b1;
      end
      if (cmd.eval && !base_valid) begin
        acc  <= acc_sum;
        seen <= seen_inc[SEEN_W-1:0];
      end
      if (cmd.base_set) begin
        base_valid <= 1'b1;
      end
      if (cmd.set_cond) begin
        last_cond <= cond;
      end
    end
  end

  // history memory
  always_ff @(posedge clk) begin
    if (cmd.log_en) begin
      mem[wr_pos] <= cmd.log_ev;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_pos <= '0;
      fill   <= '0;
      rd_ptr <= '0;
      idx    <= '0;
    end else begin
      if (cmd.log_en) begin
        wr_pos <= (wr_pos == AW'(HISTORY_DEPTH - 1)) ? '0 : wr_pos + AW'(1);
        if (fill != FILL_W'(HISTORY_DEPTH)) begin
          fill <= fill + FILL_W'(1);
        end
      end
      if (cmd.dump_start) begin
        rd_ptr <= (fill == FILL_W'(HISTORY_DEPTH)) ? wr_pos : '0;
        idx    <= '0;
      end
      if (cmd.entry_load) begin
        rd_ptr <= (rd_ptr == AW'(HISTORY_DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
        idx    <= idx_inc;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.entry_load || cmd.report_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    load_word = '0;
    if (cmd.report_load) begin
      load_word.kind            = KIND_REPORT;
      load_word.x_mg            = x_mg;
      load_word.y_mg            = y_mg;
      load_word.z_mg            = z_mg;
      load_word.magnitude_mg    = root;
      load_word.deviation_mg    = dev;
      load_word.baseline_done   = base_valid;
      load_word.vibration_level = level;
      load_word.last            = 1'b1;
    end else begin
      load_word.kind            = KIND_ENTRY;
      load_word.entry_position  = pos32[POS_W-1:0];
      load_word.entry_event     = rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.entry_load || cmd.report_load) begin
      out_data <= load_word;
    end
  end

  always_comb begin
    sts.self_test_ok = cap_ok;
    sts.first_logged = first_logged;
    sts.completing   = !base_valid && (seen_inc >= DIVISOR);
    sts.cond         = cond;
    sts.last_cond    = last_cond;
    sts.dump_last    = (idx_inc == fill);
    sts.out_free     = !out_valid || out_ready;
  end

endmodule

`default_nettype wire

>>> rtl/core/vcm_controller.sv
// ----------------------------------------------------------------------------
// vcm_controller
// sequencer that steps the datapath through one item
// ----------------------------------------------------------------------------
`default_nettype none

module vcm_controller (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire logic          in_func,
  output logic               in_ready,
  output vcm_pkg::cmd_t      cmd,
  input  wire vcm_pkg::sts_t sts
);
  import vcm_pkg::*;

  state_t            state;
  state_t            state_next;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = (in_func == FUNC_SAMPLE) ? ST_CONV : ST_SELF;
        end
      end
      ST_SELF: begin
        if (sts.self_test_ok) begin
          cmd.log_en = 1'b1;
          cmd.log_ev = EV_SELFTEST;
        end
        state_next = ST_IDLE;
      end
      ST_CONV: begin
        cmd.conv   = 1'b1;
        cnt_next   = '0;
        state_next = ST_SQ;
      end
      ST_SQ: begin
        cmd.sq_en    = 1'b1;
        cmd.axis     = cnt[1:0];
        cmd.sq_first = (cnt == '0);
        if (cnt == CNT_W'(AXES - 1)) begin
          cnt_next   = '0;
          state_next = ST_ROOT;
        end else begin
          cnt_next = cnt + CNT_W'(1);
        end
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        if (cnt == CNT_W'(ROOT_STEPS - 1)) begin
          cnt_next   = '0;
          state_next = ST_FIRST;
        end else begin
          cnt_next = cnt + CNT_W'(1);
        end
      end
      ST_FIRST: begin
        if (!sts.first_logged) begin
          cmd.log_en     = 1'b1;
          cmd.log_ev     = EV_VALID;
          cmd.mark_first = 1'b1;
        end
        state_next = ST_EVAL;
      end
      ST_EVAL: begin
        cmd.eval   = 1'b1;
        cnt_next   = '0;
        state_next = sts.completing ? ST_DIV : ST_JUDGE;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        state_next   = ST_BASE;
      end
      ST_BASE: begin
        cmd.base_set = 1'b1;
        state_next   = ST_JUDGE;
      end
      ST_JUDGE: begin
        cmd.judge  = 1'b1;
        state_next = ST_LOG;
      end
      ST_LOG: begin
        if (sts.cond != COND_NONE && sts.cond != sts.last_cond) begin
          cmd.log_en   = 1'b1;
          cmd.log_ev   = cond_event(sts.cond);
          cmd.set_cond = 1'b1;
          state_next   = ST_DUMP_INIT;
        end else begin
          state_next = ST_REPORT;
        end
      end
      ST_DUMP_INIT: begin
        cmd.dump_start = 1'b1;
        state_next     = ST_DUMP_RD;
      end
      ST_DUMP_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = ST_DUMP_WR;
      end
      ST_DUMP_WR: begin
        if (sts.out_free) begin
          cmd.entry_load = 1'b1;
          state_next     = sts.dump_last ? ST_REPORT : ST_DUMP_RD;
        end
      end
      ST_REPORT: begin
        if (sts.out_free) begin
          cmd.report_load = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/core/vibration_condition_monitor_top.sv
// ----------------------------------------------------------------------------
// vibration_condition_monitor_top
// accelerometer samples in, graded reports and history dumps out
//
//   channel   dir   handshake      carries
//   sensor    in    valid/ready    func, raw_x/y/z, self_test_ok
//   result    out   valid/ready    history entries, then one sample report
//   cfg       in    cfg_we only    elevated/warning/critical levels
//
// a sample is not accepted until the previous one has passed the shared
// squarer, the 12-step square root and its report; the sample that completes
// the baseline adds a reciprocal multiply and baseline load
// a condition change adds a dump start plus a memory read per history entry
// a self-test item gives no result
// output stalls hold the sequencer only when the output register is full
// reset is synchronous; the history needs no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module vibration_condition_monitor_top #(
  parameter int HISTORY_DEPTH    = 10,
  parameter int BASELINE_SAMPLES = 20
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [vcm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [vcm_pkg::LVL_W-1:0]     cfg_data,
  vcm_in_if.sink                             sensor,
  vcm_out_if.source                          result
);
  import vcm_pkg::*;

  cmd_t cmd;
  sts_t sts;
  res_t out_data;
  logic out_valid;

  vcm_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sensor.valid),
    .in_func  (sensor.func),
    .in_ready (sensor.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  vcm_datapath #(
    .HISTORY_DEPTH    (HISTORY_DEPTH),
    .BASELINE_SAMPLES (BASELINE_SAMPLES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .raw_x        (sensor.raw_x),
    .raw_y        (sensor.raw_y),
    .raw_z        (sensor.raw_z),
    .self_test_ok (sensor.self_test_ok),
    .cmd          (cmd),
    .sts          (sts),
    .out_valid    (out_valid),
    .out_ready    (result.ready),
    .out_data     (out_data)
  );

  assign result.valid           = out_valid;
  assign result.kind            = out_data.kind;
  assign result.x_mg            = out_data.x_mg;
  assign result.y_mg            = out_data.y_mg;
  assign result.z_mg            = out_data.z_mg;
  assign result.magnitude_mg    = out_data.magnitude_mg;
  assign result.deviation_mg    = out_data.deviation_mg;
  assign result.baseline_done   = out_data.baseline_done;
  assign result.vibration_level = out_data.vibration_level;
  assign result.entry_position  = out_data.entry_position;
  assign result.entry_event     = out_data.entry_event;
  assign result.last            = out_data.last;

endmodule

`default_nettype wire

>>> rtl/core/vcm_checker.sv
// ----------------------------------------------------------------------------
// vcm_checker
// port-level checks on the vibration condition monitor, bound to the top
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module vcm_checker (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               in_valid,
  input wire logic                               in_ready,
  input wire logic                               in_func,
  input wire logic                               result_valid,
  input wire logic                               result_ready,
  input wire logic                               kind,
  input wire logic signed [vcm_pkg::MG_W-1:0]    x_mg,
  input wire logic [vcm_pkg::MAG_W-1:0]          magnitude_mg,
  input wire logic [vcm_pkg::EV_W-1:0]           entry_event,
  input wire logic                               last
);
  import vcm_pkg::*;

  logic                          stalled;
  logic                          sample_acc;
  logic                          kind_ok;
  logic [1+MG_W+MAG_W+EV_W:0]    payload;

  assign stalled    = result_valid && !result_ready;
  assign sample_acc = in_valid && in_ready && (in_func == FUNC_SAMPLE);
  assign kind_ok    = (last == (kind == KIND_REPORT));
  assign payload    = {kind, x_mg, magnitude_mg, entry_event, last};

  `VCM_ASSERT_ALWAYS(a_reset_clears, clk, rst |=> !result_valid, "result valid after reset")

  `VCM_ASSERT(a_valid_held, clk, rst, stalled |=> result_valid, "result dropped while stalled")

  `VCM_ASSERT(a_payload_held, clk, rst, stalled |=> $stable(payload), "result changed in stall")

  `VCM_ASSERT(a_last_is_report, clk, rst, result_valid |-> kind_ok, "last flag wrong for kind")

  `VCM_ASSERT(a_busy_after_sample, clk, rst, sample_acc |=> !in_ready, "sample accepted while busy")

endmodule

bind vibration_condition_monitor_top vcm_checker u_vcm_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (sensor.valid),
  .in_ready     (sensor.ready),
  .in_func      (sensor.func),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .kind         (result.kind),
  .x_mg         (result.x_mg),
  .magnitude_mg (result.magnitude_mg),
  .entry_event  (result.entry_event),
  .last         (result.last)
);

`default_nettype wire
